// ===== design/packed_genotype_allele_stats_defines.svh =====
// Assertion macros shared by the packed genotype allele statistics RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the including module.
`ifndef PACKED_GENOTYPE_ALLELE_STATS_DEFINES_SVH
`define PACKED_GENOTYPE_ALLELE_STATS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PGAS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PGAS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pgas_pkg.sv =====
// Types and fixed constants of the packed genotype allele statistics block.
// Has no dependencies; every module and interface file of the block imports it.
`default_nettype none

package pgas_pkg;

    localparam int CODES_PER_WORD = 32;
    localparam int WORD_W         = 2 * CODES_PER_WORD;
    localparam int LANES          = 4;
    localparam int CODES_PER_LANE = CODES_PER_WORD / LANES;
    localparam int POS_W          = 16;
    localparam int INDIV_W        = 21;
    localparam int ALLELE_W       = 22;
    localparam int LEFT_W         = $clog2(CODES_PER_WORD + 1);
    localparam int LANE_CALLED_W  = $clog2(CODES_PER_LANE + 1);
    localparam int LANE_ALLELE_W  = $clog2(2 * CODES_PER_LANE + 1);
    localparam int WORD_CALLED_W  = $clog2(CODES_PER_WORD + 1);
    localparam int WORD_ALLELE_W  = $clog2(2 * CODES_PER_WORD + 1);

    // Two-bit genotype codes of a packed row.
    localparam logic [1:0] GENO_HOM_REF = 2'b00;
    localparam logic [1:0] GENO_MISSING = 2'b01;
    localparam logic [1:0] GENO_HET     = 2'b10;
    localparam logic [1:0] GENO_HOM_ALT = 2'b11;

    typedef struct packed {
        logic [LANE_CALLED_W-1:0] called;
        logic [LANE_ALLELE_W-1:0] alleles;
    } t_lane_cnt;

    // Totals of one finished marker row, handed from the merge stage to the dividers.
    typedef struct packed {
        logic [ALLELE_W-1:0] allele;
        logic [INDIV_W-1:0]  called;
        logic [INDIV_W-1:0]  n;
    } t_row_sum;

endpackage

`default_nettype wire

// ===== design/pgas_ifs.sv =====
// Valid/ready channel interfaces of the packed genotype allele statistics block.
// Depends on pgas_pkg for the field widths.
`default_nettype none

interface pgas_geno_if import pgas_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] geno_word;
    logic              last_word;

    modport source (output valid, output geno_word, output last_word, input ready);
    modport sink   (input valid, input geno_word, input last_word, output ready);
endinterface

interface pgas_stats_if import pgas_pkg::*; #(
    parameter int FRAC_BITS = 32
) ();
    logic                valid;
    logic                ready;
    logic [ALLELE_W-1:0] allele_count;
    logic [INDIV_W-1:0]  called_count;
    logic [FRAC_BITS:0]  allele_freq;
    logic [FRAC_BITS:0]  call_rate;
    logic                no_calls;

    modport source (output valid, output allele_count, output called_count,
                    output allele_freq, output call_rate, output no_calls, input ready);
    modport sink   (input valid, input allele_count, input called_count,
                    input allele_freq, input call_rate, input no_calls, output ready);
endinterface

interface pgas_cfg_if import pgas_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDIV_W-1:0] indiv_total;

    modport source (output valid, output indiv_total, input ready);
    modport sink   (input valid, input indiv_total, output ready);
endinterface

`default_nettype wire

// ===== design/pgas_lane.sv =====
// One counting lane: classifies a slice of genotype codes and registers its counts.
// Depends on pgas_pkg for the lane widths and the genotype codes.
`default_nettype none

module pgas_lane import pgas_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [2*CODES_PER_LANE-1:0]   i_codes,
    input  wire logic [CODES_PER_LANE-1:0]     i_valid,
    output t_lane_cnt                          o_cnt
);

    t_lane_cnt n_cnt;
    t_lane_cnt r_cnt;

    always_comb begin
        logic [1:0] code;
        n_cnt = '0;
        for (int k = 0; k < CODES_PER_LANE; k++) begin
            code = i_codes[2*k +: 2];
            if (i_valid[k]) begin
                case (code)
                    GENO_HOM_REF: begin
                        n_cnt.called = n_cnt.called + LANE_CALLED_W'(1);
                    end
                    GENO_HET: begin
                        n_cnt.called  = n_cnt.called + LANE_CALLED_W'(1);
                        n_cnt.alleles = n_cnt.alleles + LANE_ALLELE_W'(1);
                    end
                    GENO_HOM_ALT: begin
                        n_cnt.called  = n_cnt.called + LANE_CALLED_W'(1);
                        n_cnt.alleles = n_cnt.alleles + LANE_ALLELE_W'(2);
                    end
                    default: begin
                        // Missing call adds nothing.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

endmodule

`default_nettype wire

// ===== design/pgas_merge.sv =====
// Merge stage: adds the lane counts into saturating row sums and holds a finished row.
// Depends on pgas_pkg for the lane and row types.
`default_nettype none

module pgas_merge import pgas_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_last,
    input  wire t_lane_cnt          i_lane [LANES],
    input  wire logic [INDIV_W-1:0] i_n,
    input  wire logic               i_take,
    output logic                    o_row_valid,
    output t_row_sum                o_row
);

    logic [ALLELE_W-1:0]    r_allele;
    logic [INDIV_W-1:0]     r_called;
    logic                   r_row_valid;
    t_row_sum               r_row;

    logic [WORD_ALLELE_W-1:0] word_alleles;
    logic [WORD_CALLED_W-1:0] word_called;
    logic [ALLELE_W:0]        allele_sum;
    logic [INDIV_W:0]         called_sum;
    logic [ALLELE_W-1:0]      n_allele;
    logic [INDIV_W-1:0]       n_called;

    always_comb begin
        word_alleles = '0;
        word_called  = '0;
        for (int k = 0; k < LANES; k++) begin
            word_alleles = word_alleles + WORD_ALLELE_W'(i_lane[k].alleles);
            word_called  = word_called + WORD_CALLED_W'(i_lane[k].called);
        end
        allele_sum = {1'b0, r_allele} + (ALLELE_W+1)'(word_alleles);
        called_sum = {1'b0, r_called} + (INDIV_W+1)'(word_called);
        n_allele   = allele_sum[ALLELE_W] ? '1 : allele_sum[ALLELE_W-1:0];
        n_called   = called_sum[INDIV_W] ? '1 : called_sum[INDIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allele    <= '0;
            r_called    <= '0;
            r_row_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_row_valid <= 1'b0;
            end
            if (i_valid) begin
                if (i_last) begin
                    r_row.allele <= n_allele;
                    r_row.called <= n_called;
                    r_row.n      <= i_n;
                    r_row_valid  <= 1'b1;
                    r_allele     <= '0;
                    r_called     <= '0;
                end else begin
                    r_allele <= n_allele;
                    r_called <= n_called;
                end
            end
        end
    end

    assign o_row_valid = r_row_valid;
    assign o_row       = r_row;

endmodule

`default_nettype wire

// ===== design/pgas_div.sv =====
// Fixed-point ratio unit: one quotient bit per cycle, clamped to one.
// Depends on pgas_pkg only by convention; all widths come from its parameters.
`default_nettype none

module pgas_div import pgas_pkg::*; #(
    parameter int W         = 22,
    parameter int FRAC_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [W-1:0]       i_num,
    input  wire logic [W-1:0]       i_den,
    input  wire logic               i_take,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [FRAC_BITS:0]      o_quot
);

    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    logic                 r_busy;
    logic                 r_done;
    logic [W-1:0]         r_rem;
    logic [W-1:0]         r_den;
    logic [FRAC_BITS:0]   r_quot;
    logic [CW-1:0]        r_cnt;

    logic [W:0]           shifted;
    logic                 fits;
    logic [W:0]           diff;

    assign shifted = {r_rem, 1'b0};
    assign fits    = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            if (i_den == '0) begin
                // Undefined ratio reads as zero.
                r_quot <= '0;
                r_done <= 1'b1;
            end else if (i_num >= i_den) begin
                // A ratio of one or more is clamped to one.
                r_quot <= ONE_Q;
                r_done <= 1'b1;
            end else begin
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
                r_cnt  <= CW'(FRAC_BITS);
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem  <= fits ? diff[W-1:0] : shifted[W-1:0];
            r_quot <= {r_quot[FRAC_BITS-1:0], fits};
            r_cnt  <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_take) begin
            r_done <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== design/packed_genotype_allele_stats.sv =====
// Top level of the packed genotype allele statistics block: lanes, merge, ratio units.
// Depends on pgas_pkg, pgas_ifs, pgas_lane, pgas_merge, pgas_div and the defines header.
//
//   Channel   Direction  Handshake       Payload
//   i_geno    in         valid / ready   geno_word[63:0], last_word
//   o_stats   out        valid / ready   allele_count, called_count, allele_freq,
//                                        call_rate, no_calls
//   i_cfg     in         valid / ready   indiv_total[20:0] (ready is always high)
//
// Words are taken at one per cycle, but none while a row end waits in the lane stage or a
// finished row waits in the merge stage. Each row end starts two ratio units that retire
// one quotient bit per cycle; a row end that arrives while the previous row still waits
// for them stalls the input. The result moves from the lane registers through the merge
// stage and the ratio units to the output register, where a stalled result waits. Reset is
// synchronous and active low; it clears the row sums and sets the individual count to one.
`default_nettype none
`include "packed_genotype_allele_stats_defines.svh"

module packed_genotype_allele_stats import pgas_pkg::*; #(
    parameter int MAX_INDIVS = 1048576,
    parameter int FRAC_BITS  = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    pgas_geno_if.sink       i_geno,
    pgas_cfg_if.sink        i_cfg,
    pgas_stats_if.source    o_stats
);

    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    // Configuration register and the effective individual count it implies.
    logic [INDIV_W-1:0] r_indiv_total;
    logic [INDIV_W-1:0] eff_n;

    // Word position inside the current row, saturating.
    logic [POS_W-1:0]   r_pos;

    // Lane stage: valid and row-end flag of the word held in the lane registers.
    logic               r_s1_valid;
    logic               r_s1_last;

    logic               in_ready;
    logic               in_accept;

    // Codes of the current word that fall below the individual count.
    logic [INDIV_W-1:0]        base;
    logic [INDIV_W-1:0]        remain;
    logic [LEFT_W-1:0]         left;
    logic [CODES_PER_WORD-1:0] code_valid;

    t_lane_cnt          lane_cnt [LANES];

    logic               row_valid;
    t_row_sum           row;

    // Ratio units and the counts that travel alongside them.
    logic               div_start;
    logic               div_take;
    logic               busy_f, done_f, busy_r, done_r;
    logic [FRAC_BITS:0] quot_f, quot_r;
    logic [ALLELE_W-1:0] r_res_allele;
    logic [INDIV_W-1:0]  r_res_called;

    // Output register.
    logic                r_out_valid;
    logic [ALLELE_W-1:0] r_out_allele;
    logic [INDIV_W-1:0]  r_out_called;
    logic [FRAC_BITS:0]  r_out_freq;
    logic [FRAC_BITS:0]  r_out_rate;
    logic                r_out_none;

    // The count is clamped to the largest row the block is built for.
    assign eff_n = ({11'b0, r_indiv_total} > 32'(MAX_INDIVS)) ? INDIV_W'(MAX_INDIVS)
                                                              : r_indiv_total;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_indiv_total <= INDIV_W'(1);
        end else if (i_cfg.valid) begin
            r_indiv_total <= i_cfg.indiv_total;
        end
    end

    // No word may enter while a row end is in flight in the lane stage or a row waits for the
    // ratio units; at most one finished row is ever held in the merge stage.
    assign in_ready     = !row_valid && !(r_s1_valid && r_s1_last);
    assign i_geno.ready = in_ready;
    assign in_accept    = i_geno.valid && in_ready;

    always_comb begin
        base   = {r_pos, 5'b0};
        remain = eff_n - base;
        if (base >= eff_n) begin
            left = '0;
        end else if (remain >= INDIV_W'(CODES_PER_WORD)) begin
            left = LEFT_W'(CODES_PER_WORD);
        end else begin
            left = remain[LEFT_W-1:0];
        end
        for (int k = 0; k < CODES_PER_WORD; k++) begin
            code_valid[k] = LEFT_W'(k) < left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
            if (in_accept) begin
                if (i_geno.last_word) begin
                    r_pos <= '0;
                end else if (r_pos != '1) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_last <= i_geno.last_word;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        pgas_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (in_accept),
            .i_codes (i_geno.geno_word[2*CODES_PER_LANE*g +: 2*CODES_PER_LANE]),
            .i_valid (code_valid[CODES_PER_LANE*g +: CODES_PER_LANE]),
            .o_cnt   (lane_cnt[g])
        );
    end

    pgas_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_last      (r_s1_last),
        .i_lane      (lane_cnt),
        .i_n         (eff_n),
        .i_take      (div_start),
        .o_row_valid (row_valid),
        .o_row       (row)
    );

    // Both ratio units start together once they have handed off their last results.
    assign div_start = row_valid && !busy_f && !busy_r && !done_f && !done_r;
    assign div_take  = done_f && done_r && (!r_out_valid || o_stats.ready);

    pgas_div #(.W(ALLELE_W), .FRAC_BITS(FRAC_BITS)) u_div_freq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (row.allele),
        .i_den   ({row.called, 1'b0}),
        .i_take  (div_take),
        .o_busy  (busy_f),
        .o_done  (done_f),
        .o_quot  (quot_f)
    );

    pgas_div #(.W(INDIV_W), .FRAC_BITS(FRAC_BITS)) u_div_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (row.called),
        .i_den   (row.n),
        .i_take  (div_take),
        .o_busy  (busy_r),
        .o_done  (done_r),
        .o_quot  (quot_r)
    );

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_res_allele <= row.allele;
            r_res_called <= row.called;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (div_take) begin
            r_out_valid <= 1'b1;
        end else if (o_stats.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_take) begin
            r_out_allele <= r_res_allele;
            r_out_called <= r_res_called;
            r_out_freq   <= quot_f;
            r_out_rate   <= quot_r;
            r_out_none   <= (r_res_called == '0);
        end
    end

    assign o_stats.valid        = r_out_valid;
    assign o_stats.allele_count = r_out_allele;
    assign o_stats.called_count = r_out_called;
    assign o_stats.allele_freq  = r_out_freq;
    assign o_stats.call_rate    = r_out_rate;
    assign o_stats.no_calls     = r_out_none;

    `PGAS_ASSERT_IMP(a_row_slot_free, r_s1_valid && r_s1_last, !row_valid, "row end overruns held row")
    `PGAS_ASSERT_NXT(a_div_holds, done_f && done_r && !div_take, done_f && done_r, "ratio result dropped")
    `PGAS_ASSERT_IMP(a_no_calls_freq, o_stats.valid && o_stats.no_calls, o_stats.allele_freq == '0, "frequency without calls")
    `PGAS_ASSERT_IMP(a_rate_bound, o_stats.valid, o_stats.call_rate <= ONE_Q, "call rate above one")

endmodule

`default_nettype wire
